FILE: rtl/prtu_pkg.sv
// Shared types, action codes and fixed widths for the planar rigid transform unit.
package prtu_pkg;

  // Action codes
  localparam logic [2:0] ACT_POINT   = 3'd0;
  localparam logic [2:0] ACT_VECTOR  = 3'd1;
  localparam logic [2:0] ACT_TWIST   = 3'd2;
  localparam logic [2:0] ACT_INVERT  = 3'd3;
  localparam logic [2:0] ACT_COMPOSE = 3'd4;

  // Fixed-point format of positions and the twist rate
  localparam int FRACTION_BITS = 16;

  // Pipeline depth, request enters stage 1 and leaves from stage NUM_STAGES
  localparam int NUM_STAGES = 7;

  // Angle phase bits inside one quadrant
  localparam int PHASE_W = 14;

  // Quarter-wave table entries: unsigned Q1.30 in [0, 2^30]
  localparam int          TRIG_W      = 31;
  localparam int          TRIG_FRAC   = 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam longint      TRIG_ONE    = 64'sd1 <<< TRIG_FRAC;

  // Datapath widths after rounding
  localparam int PROD_W = 64;
  localparam int ROT_W  = PROD_W - TRIG_FRAC;        // rounded rotation term
  localparam int TW_W   = PROD_W - FRACTION_BITS;    // rounded twist cross term
  localparam int TOT_W  = TW_W + 1;                  // sum before saturation

  typedef logic [NUM_STAGES:1] stage_en_t;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] tf_x;
    logic signed [31:0] tf_y;
    logic signed [15:0] tf_angle;
    logic signed [31:0] arg_x;
    logic signed [31:0] arg_y;
    logic signed [15:0] arg_angle;
    logic signed [31:0] arg_omega;
  } in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [15:0] out_angle;
    logic signed [31:0] out_omega;
    logic               saturated;
  } out_t;

  // Request state through the rotation stages
  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] op_a;
    logic signed [31:0] op_b;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] w;
    logic signed [15:0] angle;
    logic signed [31:0] omega;
  } item_t;

  // What the finishing stages still need
  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [15:0] angle;
    logic signed [31:0] omega;
  } tail_t;

endpackage

FILE: rtl/prtu_sine_rom.sv
// Quarter-wave sine ROM with two registered read ports.
module prtu_sine_rom #(
  parameter int DEPTH = 1024
) (
  input  logic                                clk,
  input  logic                                rd_en,
  input  logic [$clog2(DEPTH+1)-1:0]          addr_a,
  input  logic [$clog2(DEPTH+1)-1:0]          addr_b,
  output logic [prtu_pkg::TRIG_W-1:0]         data_a_r,
  output logic [prtu_pkg::TRIG_W-1:0]         data_b_r
);

  // Entry i: Taylor series of sin(i*pi/(2*DEPTH)) in Q30, seven terms, clamped
  function automatic logic [prtu_pkg::TRIG_W-1:0] sine_entry(input int unsigned i);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    longint      sum;
    int          k;
    x   = (64'(i) * prtu_pkg::HALF_PI_Q30) / 64'(DEPTH);
    x2  = (x * x) >> prtu_pkg::TRIG_FRAC;
    t   = x;
    sum = longint'(x);
    for (k = 1; k <= 6; k++) begin
      t = (t * x2) >> prtu_pkg::TRIG_FRAC;
      case (k)
        1:       t = t / 64'd6;
        2:       t = t / 64'd20;
        3:       t = t / 64'd42;
        4:       t = t / 64'd72;
        5:       t = t / 64'd110;
        default: t = t / 64'd156;
      endcase
      if (k[0]) sum = sum - longint'(t);
      else      sum = sum + longint'(t);
    end
    if (sum < 0) sum = 0;
    if (sum > prtu_pkg::TRIG_ONE) sum = prtu_pkg::TRIG_ONE;
    return prtu_pkg::TRIG_W'(sum);
  endfunction

  logic [prtu_pkg::TRIG_W-1:0] rom [DEPTH+1];

  // Contents fixed at elaboration
  for (genvar g = 0; g <= DEPTH; g++) begin : g_rom
    localparam logic [prtu_pkg::TRIG_W-1:0] ENTRY = sine_entry(g);
    assign rom[g] = ENTRY;
  end

  // Registered reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      data_a_r <= rom[addr_a];
      data_b_r <= rom[addr_b];
    end
  end

endmodule

FILE: rtl/prtu_rotate.sv
// Rotation datapath: signed coefficients, products, and pairwise sums (stages 3 to 5).
module prtu_rotate (
  input  logic                                clk,
  input  prtu_pkg::stage_en_t                 adv,
  input  prtu_pkg::item_t                     item,
  input  logic                                neg_s,
  input  logic                                neg_c,
  input  logic [prtu_pkg::TRIG_W-1:0]         sin_mag,
  input  logic [prtu_pkg::TRIG_W-1:0]         cos_mag,
  output logic signed [prtu_pkg::PROD_W-1:0]  sx_r,
  output logic signed [prtu_pkg::PROD_W-1:0]  sy_r,
  output logic signed [prtu_pkg::PROD_W-1:0]  twx_r,
  output logic signed [prtu_pkg::PROD_W-1:0]  twy_r,
  output prtu_pkg::tail_t                     tail_r
);

  logic               inv;
  logic signed [31:0] sin_val;
  logic signed [31:0] cos_val;
  logic signed [31:0] ca_nxt;
  logic signed [31:0] cb_nxt;
  logic signed [31:0] cc_nxt;

  logic signed [31:0] ca_r;
  logic signed [31:0] cb_r;
  logic signed [31:0] cc_r;
  prtu_pkg::item_t    s3_item_r;

  logic signed [prtu_pkg::PROD_W-1:0] pa_r;
  logic signed [prtu_pkg::PROD_W-1:0] pb_r;
  logic signed [prtu_pkg::PROD_W-1:0] pc_r;
  logic signed [prtu_pkg::PROD_W-1:0] pd_r;
  logic signed [prtu_pkg::PROD_W-1:0] pwy_r;
  logic signed [prtu_pkg::PROD_W-1:0] pwx_r;
  prtu_pkg::tail_t                    s4_tail_r;

  // Stage 3: coefficients with quadrant sign; invert flips the cosine terms.
  //   x = A*ca + B*cb, y = A*cc + B*ca
  assign inv     = (item.action == prtu_pkg::ACT_INVERT);
  assign sin_val = signed'({1'b0, sin_mag});
  assign cos_val = signed'({1'b0, cos_mag});
  assign ca_nxt  = (neg_c ^ inv) ? -cos_val : cos_val;
  assign cb_nxt  = neg_s ? sin_val : -sin_val;
  assign cc_nxt  = neg_s ? -sin_val : sin_val;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      ca_r      <= ca_nxt;
      cb_r      <= cb_nxt;
      cc_r      <= cc_nxt;
      s3_item_r <= item;
    end
  end

  // Stage 4: six products in parallel
  always_ff @(posedge clk) begin
    if (adv[4]) begin
      pa_r             <= s3_item_r.op_a * ca_r;
      pb_r             <= s3_item_r.op_b * cb_r;
      pc_r             <= s3_item_r.op_a * cc_r;
      pd_r             <= s3_item_r.op_b * ca_r;
      pwy_r            <= s3_item_r.w * s3_item_r.ty;
      pwx_r            <= s3_item_r.w * s3_item_r.tx;
      s4_tail_r.action <= s3_item_r.action;
      s4_tail_r.tx     <= s3_item_r.tx;
      s4_tail_r.ty     <= s3_item_r.ty;
      s4_tail_r.angle  <= s3_item_r.angle;
      s4_tail_r.omega  <= s3_item_r.omega;
    end
  end

  // Stage 5: rotated sums; twist y term is -(w*tx)
  always_ff @(posedge clk) begin
    if (adv[5]) begin
      sx_r   <= pa_r + pb_r;
      sy_r   <= pc_r + pd_r;
      twx_r  <= pwy_r;
      twy_r  <= -pwx_r;
      tail_r <= s4_tail_r;
    end
  end

endmodule

FILE: rtl/prtu_finish.sv
// Rounding, translation or twist add, and saturation (stages 6 and 7).
module prtu_finish (
  input  logic                                clk,
  input  prtu_pkg::stage_en_t                 adv,
  input  logic signed [prtu_pkg::PROD_W-1:0]  sx,
  input  logic signed [prtu_pkg::PROD_W-1:0]  sy,
  input  logic signed [prtu_pkg::PROD_W-1:0]  twx,
  input  logic signed [prtu_pkg::PROD_W-1:0]  twy,
  input  prtu_pkg::tail_t                     tail,
  output prtu_pkg::out_t                      out_r
);

  localparam logic signed [prtu_pkg::PROD_W-1:0] HALF_TRIG =
    prtu_pkg::PROD_W'(64'sd1 <<< (prtu_pkg::TRIG_FRAC - 1));
  localparam logic signed [prtu_pkg::PROD_W-1:0] HALF_FRAC =
    prtu_pkg::PROD_W'(64'sd1 <<< (prtu_pkg::FRACTION_BITS - 1));
  localparam logic signed [prtu_pkg::TOT_W-1:0] SAT_HI =
    prtu_pkg::TOT_W'(signed'(32'h7fff_ffff));
  localparam logic signed [prtu_pkg::TOT_W-1:0] SAT_LO =
    prtu_pkg::TOT_W'(signed'(32'h8000_0000));

  logic signed [prtu_pkg::PROD_W-1:0] sx_bias;
  logic signed [prtu_pkg::PROD_W-1:0] sy_bias;
  logic signed [prtu_pkg::PROD_W-1:0] twx_bias;
  logic signed [prtu_pkg::PROD_W-1:0] twy_bias;
  logic signed [prtu_pkg::ROT_W-1:0]  rot_x;
  logic signed [prtu_pkg::ROT_W-1:0]  rot_y;
  logic signed [prtu_pkg::TW_W-1:0]   tw_x;
  logic signed [prtu_pkg::TW_W-1:0]   tw_y;
  logic                               known;
  logic signed [prtu_pkg::TOT_W-1:0]  rx_nxt;
  logic signed [prtu_pkg::TOT_W-1:0]  ry_nxt;
  logic signed [prtu_pkg::TOT_W-1:0]  addx_nxt;
  logic signed [prtu_pkg::TOT_W-1:0]  addy_nxt;

  logic signed [prtu_pkg::TOT_W-1:0]  rx_r;
  logic signed [prtu_pkg::TOT_W-1:0]  ry_r;
  logic signed [prtu_pkg::TOT_W-1:0]  addx_r;
  logic signed [prtu_pkg::TOT_W-1:0]  addy_r;
  logic signed [15:0]                 angle_r;
  logic signed [31:0]                 omega_r;

  logic signed [prtu_pkg::TOT_W-1:0]  tot_x;
  logic signed [prtu_pkg::TOT_W-1:0]  tot_y;
  logic                               hi_x;
  logic                               lo_x;
  logic                               hi_y;
  logic                               lo_y;
  prtu_pkg::out_t                     out_nxt;

  // Stage 6: round half up, floor by arithmetic shift via part-select
  assign sx_bias  = sx + HALF_TRIG;
  assign sy_bias  = sy + HALF_TRIG;
  assign twx_bias = twx + HALF_FRAC;
  assign twy_bias = twy + HALF_FRAC;
  assign rot_x    = sx_bias[prtu_pkg::PROD_W-1:prtu_pkg::TRIG_FRAC];
  assign rot_y    = sy_bias[prtu_pkg::PROD_W-1:prtu_pkg::TRIG_FRAC];
  assign tw_x     = twx_bias[prtu_pkg::PROD_W-1:prtu_pkg::FRACTION_BITS];
  assign tw_y     = twy_bias[prtu_pkg::PROD_W-1:prtu_pkg::FRACTION_BITS];

  assign known = (tail.action == prtu_pkg::ACT_POINT)  ||
                 (tail.action == prtu_pkg::ACT_VECTOR) ||
                 (tail.action == prtu_pkg::ACT_TWIST)  ||
                 (tail.action == prtu_pkg::ACT_INVERT) ||
                 (tail.action == prtu_pkg::ACT_COMPOSE);

  assign rx_nxt = known ? prtu_pkg::TOT_W'(rot_x) : '0;
  assign ry_nxt = known ? prtu_pkg::TOT_W'(rot_y) : '0;

  // Second addend per action
  always_comb begin
    case (tail.action)
      prtu_pkg::ACT_POINT,
      prtu_pkg::ACT_COMPOSE: begin
        addx_nxt = prtu_pkg::TOT_W'(tail.tx);
        addy_nxt = prtu_pkg::TOT_W'(tail.ty);
      end
      prtu_pkg::ACT_TWIST: begin
        addx_nxt = prtu_pkg::TOT_W'(tw_x);
        addy_nxt = prtu_pkg::TOT_W'(tw_y);
      end
      default: begin
        addx_nxt = '0;
        addy_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      rx_r    <= rx_nxt;
      ry_r    <= ry_nxt;
      addx_r  <= addx_nxt;
      addy_r  <= addy_nxt;
      angle_r <= tail.angle;
      omega_r <= tail.omega;
    end
  end

  // Stage 7: final add and clip to 32 bits
  assign tot_x = rx_r + addx_r;
  assign tot_y = ry_r + addy_r;
  assign hi_x  = (tot_x > SAT_HI);
  assign lo_x  = (tot_x < SAT_LO);
  assign hi_y  = (tot_y > SAT_HI);
  assign lo_y  = (tot_y < SAT_LO);

  always_comb begin
    out_nxt.out_x     = hi_x ? 32'sh7fff_ffff :
                        lo_x ? 32'sh8000_0000 : tot_x[31:0];
    out_nxt.out_y     = hi_y ? 32'sh7fff_ffff :
                        lo_y ? 32'sh8000_0000 : tot_y[31:0];
    out_nxt.out_angle = angle_r;
    out_nxt.out_omega = omega_r;
    out_nxt.saturated = hi_x | lo_x | hi_y | lo_y;
  end

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      out_r <= out_nxt;
    end
  end

endmodule

FILE: rtl/planar_rigid_transform_unit.sv
// Top level of the planar rigid transform unit: angle decode, table read and pipeline control.
//
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid / in_stall    in_data  (prtu_pkg::in_t)
//   out      output     out_valid / out_stall  out_data (prtu_pkg::out_t)
//
// Seven register stages; one request enters per cycle unless in_stall is high. The
// registered sine table read and the 32x32 product stage each have a register stage
// of their own.
// Reset clears the stage valid bits only; the sine table is constant, no clearing pass.
// out_stall holds the last stage; stages behind it keep filling until they meet
// a full stage, so empty slots are squeezed out and nothing is dropped or repeated.
module planar_rigid_transform_unit #(
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  prtu_pkg::in_t    in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output prtu_pkg::out_t   out_data
);

  localparam int IW = $clog2(SINE_TABLE_DEPTH);
  localparam int AW = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int PW = prtu_pkg::PHASE_W + AW;

  prtu_pkg::stage_en_t adv;
  prtu_pkg::stage_en_t valid_r;
  prtu_pkg::stage_en_t valid_nxt;

  logic [15:0]                 ta;
  logic [1:0]                  quad_s;
  logic [1:0]                  quad_c;
  logic [prtu_pkg::PHASE_W-1:0] phase;
  logic [PW-1:0]               phase_scaled;
  logic [IW-1:0]               idx;
  logic [AW-1:0]               addr_s_nxt;
  logic [AW-1:0]               addr_c_nxt;
  logic                        inv;
  prtu_pkg::item_t             item_nxt;

  prtu_pkg::item_t             s1_item_r;
  logic [AW-1:0]               s1_addr_s_r;
  logic [AW-1:0]               s1_addr_c_r;
  logic                        s1_neg_s_r;
  logic                        s1_neg_c_r;
  prtu_pkg::item_t             s2_item_r;
  logic                        s2_neg_s_r;
  logic                        s2_neg_c_r;

  logic [prtu_pkg::TRIG_W-1:0]        sin_mag_r;
  logic [prtu_pkg::TRIG_W-1:0]        cos_mag_r;
  logic signed [prtu_pkg::PROD_W-1:0] sx;
  logic signed [prtu_pkg::PROD_W-1:0] sy;
  logic signed [prtu_pkg::PROD_W-1:0] twx;
  logic signed [prtu_pkg::PROD_W-1:0] twy;
  prtu_pkg::tail_t                    tail;

  // Stage advance: a stage moves when empty or when the stage after it moves
  always_comb begin
    adv[prtu_pkg::NUM_STAGES] = !valid_r[prtu_pkg::NUM_STAGES] || !out_stall;
    for (int k = prtu_pkg::NUM_STAGES - 1; k >= 1; k--) begin
      adv[k] = !valid_r[k] || adv[k+1];
    end
  end

  always_comb begin
    valid_nxt    = valid_r;
    if (adv[1]) valid_nxt[1] = in_valid;
    for (int k = 2; k <= prtu_pkg::NUM_STAGES; k++) begin
      if (adv[k]) valid_nxt[k] = valid_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_stall  = !adv[1];
  assign out_valid = valid_r[prtu_pkg::NUM_STAGES];

  // Stage 1: quadrant and table index for sine and cosine (cos a = sin(a + quarter))
  assign ta           = in_data.tf_angle;
  assign quad_s       = ta[15:14];
  assign quad_c       = quad_s + 2'd1;
  assign phase        = ta[prtu_pkg::PHASE_W-1:0];
  assign phase_scaled = PW'(phase) * PW'(SINE_TABLE_DEPTH);
  assign idx          = phase_scaled[prtu_pkg::PHASE_W +: IW];
  assign addr_s_nxt   = quad_s[0] ? AW'(SINE_TABLE_DEPTH) - AW'(idx) : AW'(idx);
  assign addr_c_nxt   = quad_c[0] ? AW'(SINE_TABLE_DEPTH) - AW'(idx) : AW'(idx);

  // Operand selection and the angle and rate results
  assign inv = (in_data.action == prtu_pkg::ACT_INVERT);

  always_comb begin
    item_nxt.action = in_data.action;
    item_nxt.op_a   = inv ? in_data.tf_x : in_data.arg_x;
    item_nxt.op_b   = inv ? in_data.tf_y : in_data.arg_y;
    item_nxt.tx     = in_data.tf_x;
    item_nxt.ty     = in_data.tf_y;
    item_nxt.w      = in_data.arg_omega;
    item_nxt.omega  = '0;
    case (in_data.action)
      prtu_pkg::ACT_COMPOSE: item_nxt.angle = in_data.tf_angle + in_data.arg_angle;
      prtu_pkg::ACT_INVERT:  item_nxt.angle = 16'sd0 - in_data.tf_angle;
      prtu_pkg::ACT_TWIST: begin
        item_nxt.angle = '0;
        item_nxt.omega = in_data.arg_omega;
      end
      default:               item_nxt.angle = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_item_r   <= item_nxt;
      s1_addr_s_r <= addr_s_nxt;
      s1_addr_c_r <= addr_c_nxt;
      s1_neg_s_r  <= quad_s[1];
      s1_neg_c_r  <= quad_c[1];
    end
  end

  // Stage 2: table read alongside the request
  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s2_item_r  <= s1_item_r;
      s2_neg_s_r <= s1_neg_s_r;
      s2_neg_c_r <= s1_neg_c_r;
    end
  end

  prtu_sine_rom #(
    .DEPTH (SINE_TABLE_DEPTH)
  ) u_rom (
    .clk      (clk),
    .rd_en    (adv[2]),
    .addr_a   (s1_addr_s_r),
    .addr_b   (s1_addr_c_r),
    .data_a_r (sin_mag_r),
    .data_b_r (cos_mag_r)
  );

  // Stages 3 to 5
  prtu_rotate u_rotate (
    .clk     (clk),
    .adv     (adv),
    .item    (s2_item_r),
    .neg_s   (s2_neg_s_r),
    .neg_c   (s2_neg_c_r),
    .sin_mag (sin_mag_r),
    .cos_mag (cos_mag_r),
    .sx_r    (sx),
    .sy_r    (sy),
    .twx_r   (twx),
    .twy_r   (twy),
    .tail_r  (tail)
  );

  // Stages 6 and 7
  prtu_finish u_finish (
    .clk   (clk),
    .adv   (adv),
    .sx    (sx),
    .sy    (sy),
    .twx   (twx),
    .twy   (twy),
    .tail  (tail),
    .out_r (out_data)
  );

endmodule

FILE: test/testbench.sv
// Self-checking testbench for the planar rigid transform unit: scoreboard class and top module.
module testbench;
  localparam int TABLE_DEPTH  = 1024;
  localparam int RANDOM_ITEMS = 1030;
  localparam int STALL_LIMIT  = 2000;
  localparam int QUIET_FIRST  = 400;
  localparam int QUIET_LAST   = 600;

  localparam logic signed [31:0] POS_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] POS_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] Q_ONE   = 32'sh0001_0000;
  localparam logic signed [15:0] ANG_MAX = 16'sh7FFF;
  localparam logic signed [15:0] ANG_MIN = 16'sh8000;
  localparam logic signed [15:0] QUARTER = 16'sh4000;
  localparam logic signed [15:0] EIGHTH  = 16'sh2000;

  // Predicts each result from the accepted request and checks the results in order
  class pose_scoreboard;
    longint         sine_lut[TABLE_DEPTH+1];
    prtu_pkg::out_t pending_results[$];
    int             error_count;
    int             checked_count;
    int             clipped_count;
    int             action_seen[8];

    function new();
      for (int i = 0; i <= TABLE_DEPTH; i++) sine_lut[i] = quarter_sine(i);
      error_count   = 0;
      checked_count = 0;
      clipped_count = 0;
      foreach (action_seen[i]) action_seen[i] = 0;
    endfunction

    // Quarter-wave entry, Q1.30, from a truncated Taylor series
    function longint quarter_sine(int i);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      longint      acc;
      x   = (64'(i) * prtu_pkg::HALF_PI_Q30) / 64'(TABLE_DEPTH);
      x2  = (x * x) >> 30;
      t   = x;
      acc = longint'(x);
      for (int k = 1; k <= 6; k++) begin
        t = ((t * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) acc -= longint'(t);
        else acc += longint'(t);
      end
      if (acc < 0) acc = 0;
      if (acc > prtu_pkg::TRIG_ONE) acc = prtu_pkg::TRIG_ONE;
      return acc;
    endfunction

    // Quadrant fold of the binary angle onto the table
    function longint sine_of(logic [15:0] ang);
      logic [1:0] quad;
      int         idx;
      longint     v;
      quad = ang[15:14];
      idx  = (int'(ang[13:0]) * TABLE_DEPTH) >> 14;
      v    = quad[0] ? sine_lut[TABLE_DEPTH - idx] : sine_lut[idx];
      return quad[1] ? -v : v;
    endfunction

    // Round to nearest, ties toward +inf
    function longint round_q(longint v, int n);
      return (v + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function longint clip32(longint v, inout bit flag);
      if (v > longint'(32'sh7FFF_FFFF)) begin
        flag = 1'b1;
        return longint'(32'sh7FFF_FFFF);
      end
      if (v < longint'(32'sh8000_0000)) begin
        flag = 1'b1;
        return longint'(32'sh8000_0000);
      end
      return v;
    endfunction

    function prtu_pkg::out_t compute_transform(prtu_pkg::in_t req);
      longint         tx, ty, ax, ay, w, s, c, rx, ry;
      bit             clipped;
      prtu_pkg::out_t res;
      res     = '0;
      clipped = 1'b0;
      tx = longint'(req.tf_x);
      ty = longint'(req.tf_y);
      ax = longint'(req.arg_x);
      ay = longint'(req.arg_y);
      w  = longint'(req.arg_omega);
      s  = sine_of(req.tf_angle);
      c  = sine_of(16'(req.tf_angle + 16'h4000));
      rx = 0;
      ry = 0;
      case (req.action)
        prtu_pkg::ACT_POINT, prtu_pkg::ACT_COMPOSE: begin
          rx = round_q(ax * c - ay * s, 30) + tx;
          ry = round_q(ax * s + ay * c, 30) + ty;
          if (req.action == prtu_pkg::ACT_COMPOSE)
            res.out_angle = 16'(req.tf_angle + req.arg_angle);
        end
        prtu_pkg::ACT_VECTOR: begin
          rx = round_q(ax * c - ay * s, 30);
          ry = round_q(ax * s + ay * c, 30);
        end
        prtu_pkg::ACT_TWIST: begin
          rx = round_q(w * ty, prtu_pkg::FRACTION_BITS) + round_q(ax * c - ay * s, 30);
          ry = round_q(-(w * tx), prtu_pkg::FRACTION_BITS) + round_q(ax * s + ay * c, 30);
          res.out_omega = req.arg_omega;
        end
        prtu_pkg::ACT_INVERT: begin
          rx = round_q(-(tx * c + ty * s), 30);
          ry = round_q(tx * s - ty * c, 30);
          // negation wraps, so a half turn stays a half turn
          res.out_angle = 16'(-req.tf_angle);
        end
        default: begin
          // unused codes give an all-zero result
        end
      endcase
      rx = clip32(rx, clipped);
      ry = clip32(ry, clipped);
      res.out_x     = 32'(rx);
      res.out_y     = 32'(ry);
      res.saturated = clipped;
      return res;
    endfunction

    function void note_request(prtu_pkg::in_t req);
      prtu_pkg::out_t res;
      res = compute_transform(req);
      action_seen[req.action]++;
      if (res.saturated) clipped_count++;
      pending_results.push_back(res);
    endfunction

    function void check_result(prtu_pkg::out_t got);
      prtu_pkg::out_t want;
      if (pending_results.size() == 0) begin
        $error("result with no pending request: x=%0d y=%0d", got.out_x, got.out_y);
        error_count++;
        return;
      end
      want = pending_results.pop_front();
      checked_count++;
      if (got.out_x !== want.out_x) begin
        $error("out_x expected %0d got %0d", want.out_x, got.out_x);
        error_count++;
      end
      if (got.out_y !== want.out_y) begin
        $error("out_y expected %0d got %0d", want.out_y, got.out_y);
        error_count++;
      end
      if (got.out_angle !== want.out_angle) begin
        $error("out_angle expected %0d got %0d", want.out_angle, got.out_angle);
        error_count++;
      end
      if (got.out_omega !== want.out_omega) begin
        $error("out_omega expected %0d got %0d", want.out_omega, got.out_omega);
        error_count++;
      end
      if (got.saturated !== want.saturated) begin
        $error("saturated expected %0b got %0b", want.saturated, got.saturated);
        error_count++;
      end
    endfunction
  endclass

  logic           clk       = 1'b0;
  logic           rst_n     = 1'b0;
  logic           in_valid  = 1'b0;
  logic           in_stall;
  prtu_pkg::in_t  in_data   = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  prtu_pkg::out_t out_data;

  bit             no_idle = 1'b0;
  int             idle_cycles = 0;
  pose_scoreboard sb = new();

  planar_rigid_transform_unit #(
    .SINE_TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit take_break();
    return !no_idle && ($urandom_range(99) < 33);
  endfunction

  // Mostly moderate coordinates, sometimes extremes or full-range words
  function automatic logic signed [31:0] pick_coord();
    case ($urandom_range(9))
      0: return POS_MAX;
      1: return POS_MIN;
      2: return '0;
      3, 4: return $urandom;
      default: return int'($urandom_range(33554431)) - 16777216;
    endcase
  endfunction

  function automatic logic signed [31:0] pick_rate();
    case ($urandom_range(7))
      0: return POS_MAX;
      1: return POS_MIN;
      2: return $urandom;
      default: return int'($urandom_range(1048575)) - 524288;
    endcase
  endfunction

  function automatic logic signed [15:0] pick_angle();
    case ($urandom_range(9))
      0: return ANG_MIN;
      1: return ANG_MAX;
      2: return QUARTER;
      3: return 16'(-QUARTER);
      default: return 16'($urandom);
    endcase
  endfunction

  // Offer one request and hold it until the block takes it
  task automatic send_request(input prtu_pkg::in_t req);
    while (take_break()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(req);
    @(negedge clk);
  endtask

  task automatic send_fields(input logic [2:0] act,
                             input logic signed [31:0] tx, input logic signed [31:0] ty,
                             input logic signed [15:0] ta,
                             input logic signed [31:0] ax, input logic signed [31:0] ay,
                             input logic signed [15:0] aa, input logic signed [31:0] w);
    prtu_pkg::in_t req;
    req.action    = act;
    req.tf_x      = tx;
    req.tf_y      = ty;
    req.tf_angle  = ta;
    req.arg_x     = ax;
    req.arg_y     = ay;
    req.arg_angle = aa;
    req.arg_omega = w;
    send_request(req);
  endtask

  // Receiver stall, decided once per cycle
  always @(negedge clk) out_stall <= take_break();

  // Result check and stall watchdog
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    if ((rst_n && out_valid && !out_stall) || (rst_n && in_valid && !in_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no request or result moved for %0d cycles", STALL_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    prtu_pkg::in_t req;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: identity, quadrants, extremes, saturation, wrap, unused codes
    send_fields(prtu_pkg::ACT_POINT, '0, '0, '0, '0, '0, '0, '0);
    send_fields(prtu_pkg::ACT_POINT, 3 * Q_ONE, -4 * Q_ONE, '0, Q_ONE, 2 * Q_ONE, '0, '0);
    send_fields(prtu_pkg::ACT_POINT, Q_ONE, Q_ONE, QUARTER, 5 * Q_ONE, -3 * Q_ONE, '0, '0);
    send_fields(prtu_pkg::ACT_POINT, POS_MIN, POS_MIN, '0, POS_MIN, '0, '0, '0);
    send_fields(prtu_pkg::ACT_POINT, 32'sd1, 32'sd1, EIGHTH, 32'sd1, 32'sd1, '0, '0);
    send_fields(prtu_pkg::ACT_VECTOR, POS_MAX, POS_MAX, ANG_MIN, 7 * Q_ONE, Q_ONE, '0, '0);
    send_fields(prtu_pkg::ACT_VECTOR, '0, '0, ANG_MAX, POS_MAX, POS_MIN, '0, '0);
    send_fields(prtu_pkg::ACT_VECTOR, '0, '0, 16'(-QUARTER), POS_MIN, POS_MIN, '0, '0);
    send_fields(prtu_pkg::ACT_TWIST, 2 * Q_ONE, -Q_ONE, QUARTER, Q_ONE, Q_ONE, '0, Q_ONE / 2);
    send_fields(prtu_pkg::ACT_TWIST, POS_MIN, POS_MIN, '0, POS_MAX, POS_MAX, '0, POS_MAX);
    send_fields(prtu_pkg::ACT_TWIST, POS_MAX, POS_MAX, ANG_MIN, POS_MIN, POS_MIN, '0, POS_MIN);
    send_fields(prtu_pkg::ACT_TWIST, Q_ONE, Q_ONE, EIGHTH, 3 * Q_ONE, '0, ANG_MAX, '0);
    send_fields(prtu_pkg::ACT_INVERT, Q_ONE, 2 * Q_ONE, ANG_MIN, '0, '0, '0, '0);
    send_fields(prtu_pkg::ACT_INVERT, POS_MIN, POS_MIN, '0, POS_MAX, '0, '0, POS_MAX);
    send_fields(prtu_pkg::ACT_INVERT, 5 * Q_ONE, -Q_ONE, EIGHTH, '0, '0, '0, '0);
    send_fields(prtu_pkg::ACT_INVERT, POS_MAX, POS_MIN, ANG_MAX, '0, '0, '0, '0);
    send_fields(prtu_pkg::ACT_COMPOSE, Q_ONE, Q_ONE, ANG_MAX, Q_ONE, '0, 16'sd1, '0);
    send_fields(prtu_pkg::ACT_COMPOSE, POS_MAX, POS_MAX, '0, POS_MAX, POS_MAX, ANG_MIN, '0);
    send_fields(prtu_pkg::ACT_COMPOSE, '0, '0, ANG_MIN, Q_ONE, Q_ONE, ANG_MIN, POS_MIN);
    for (int a = prtu_pkg::ACT_COMPOSE + 1; a < 8; a++)
      send_fields(3'(a), POS_MAX, POS_MIN, ANG_MAX, POS_MIN, POS_MAX, ANG_MIN, POS_MAX);

    // Random requests, with a stretch where neither side idles
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      no_idle = (n >= QUIET_FIRST) && (n < QUIET_LAST);
      if ($urandom_range(15) == 0)
        req.action = 3'($urandom_range(7, prtu_pkg::ACT_COMPOSE + 1));
      else req.action = 3'($urandom_range(prtu_pkg::ACT_COMPOSE));
      req.tf_x      = pick_coord();
      req.tf_y      = pick_coord();
      req.tf_angle  = pick_angle();
      req.arg_x     = pick_coord();
      req.arg_y     = pick_coord();
      req.arg_angle = pick_angle();
      req.arg_omega = pick_rate();
      send_request(req);
    end
    no_idle = 1'b0;
    in_valid <= 1'b0;

    // Drain, then watch for stray results
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (4 * prtu_pkg::NUM_STAGES) @(posedge clk);

    if (sb.pending_results.size() != 0) begin
      $error("%0d results never arrived", sb.pending_results.size());
      sb.error_count++;
    end
    $display("Covered %0d results: point %0d, vector %0d, twist %0d, invert %0d, compose %0d,",
             sb.checked_count, sb.action_seen[prtu_pkg::ACT_POINT],
             sb.action_seen[prtu_pkg::ACT_VECTOR], sb.action_seen[prtu_pkg::ACT_TWIST],
             sb.action_seen[prtu_pkg::ACT_INVERT], sb.action_seen[prtu_pkg::ACT_COMPOSE]);
    $display("  %0d with unused codes, %0d clipped; %0d mismatches",
             sb.action_seen[5] + sb.action_seen[6] + sb.action_seen[7],
             sb.clipped_count, sb.error_count);
    if (sb.error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
